### hw/rtl/rtcb_pkg.sv
// Shared types and constants for the range-to-CIDR block splitter.
package rtcb_pkg;

    localparam int START_W  = 32;
    localparam int COUNT_W  = 33;
    localparam int BASE_W   = 32;
    localparam int PREFIX_W = 6;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_zero;
        logic last;
    } dp_status_t;

endpackage

### hw/rtl/rtcb_in_if.sv
// Input channel: one address range per beat.
interface rtcb_in_if;
    import rtcb_pkg::*;

    logic                valid;
    logic                ready;
    logic [START_W-1:0]  start_address;
    logic [COUNT_W-1:0]  range_count;

    modport source (output valid, output start_address, output range_count, input ready);
    modport sink   (input valid, input start_address, input range_count, output ready);
endinterface

### hw/rtl/rtcb_out_if.sv
// Output channel: one CIDR block per beat.
interface rtcb_out_if;
    import rtcb_pkg::*;

    logic                valid;
    logic                ready;
    logic [BASE_W-1:0]   block_base;
    logic [PREFIX_W-1:0] prefix_length;
    logic                last_block;

    modport source (output valid, output block_base, output prefix_length,
                    output last_block, input ready);
    modport sink   (input valid, input block_base, input prefix_length,
                    input last_block, output ready);
endinterface

### hw/rtl/rtcb_ctrl.sv
// Controller: sequences range load and per-block steps, owns output valid.
module rtcb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  rtcb_pkg::dp_status_t status,
    output rtcb_pkg::dp_cmd_t    cmd
);
    import rtcb_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !status.in_zero)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (out_free && status.last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid && !status.in_zero;
            end
            ST_RUN:
            begin
                cmd.step = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### hw/rtl/rtcb_dp.sv
// Datapath: current address and remaining count, block size pick, output register.
module rtcb_dp #(
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                           clk,
    input  rtcb_pkg::dp_cmd_t              cmd,
    output rtcb_pkg::dp_status_t           status,
    input  logic [rtcb_pkg::START_W-1:0]   start_address,
    input  logic [rtcb_pkg::COUNT_W-1:0]   range_count,
    output logic [rtcb_pkg::BASE_W-1:0]    block_base,
    output logic [rtcb_pkg::PREFIX_W-1:0]  prefix_length,
    output logic                           last_block
);
    import rtcb_pkg::*;

    localparam int AW       = ADDRESS_WIDTH;
    localparam int SW       = AW + 1;           // sizes reach 2^AW
    localparam int SMEAR_N  = $clog2(SW);

    logic [AW-1:0]       addr_reg, addr_next;
    logic [SW-1:0]       left_reg, left_next;
    logic [BASE_W-1:0]   base_reg;
    logic [PREFIX_W-1:0] prefix_reg;
    logic                last_reg;

    logic [AW-1:0]       start_masked;
    logic [SW-1:0]       room;
    logic [COUNT_W:0]    room_wide;
    logic [SW-1:0]       clamped;
    logic [SW-1:0]       low_bit;
    logic [SW-1:0]       smear;
    logic [SW-1:0]       high_bit;
    logic [SW-1:0]       size;
    logic [PREFIX_W-1:0] size_log;

    // range clamp at load: count may not run past the top address
    assign start_masked = start_address[AW-1:0];
    assign room         = {1'b1, {AW{1'b0}}} - {1'b0, start_masked};
    assign room_wide    = (COUNT_W+1)'(room);
    assign clamped      = ({1'b0, range_count} > room_wide) ? room : range_count[SW-1:0];

    // alignment of the current address; zero is aligned to the whole space
    always_comb
    begin
        if (addr_reg == '0)
            low_bit = {1'b1, {AW{1'b0}}};
        else
            low_bit = {1'b0, addr_reg & (~addr_reg + AW'(1))};
    end

    // largest power of two not above the remaining count
    always_comb
    begin
        smear = left_reg;
        for (int i = 0; i < SMEAR_N; i++)
            smear = smear | (smear >> (1 << i));
        high_bit = smear & ~(smear >> 1);
    end

    assign size = (low_bit < high_bit) ? low_bit : high_bit;

    always_comb
    begin
        size_log = '0;
        for (int i = 0; i < SW; i++)
            if (size[i])
                size_log = size_log | PREFIX_W'(i);
    end

    always_comb
    begin
        status.in_zero = (range_count == '0);
        status.last    = (left_reg == size);
    end

    always_comb
    begin
        addr_next = addr_reg;
        left_next = left_reg;
        if (cmd.load)
        begin
            addr_next = start_masked;
            left_next = clamped;
        end
        else if (cmd.step)
        begin
            addr_next = addr_reg + size[AW-1:0];
            left_next = left_reg - size;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        left_reg <= left_next;
        if (cmd.step)
        begin
            base_reg   <= BASE_W'(addr_reg);
            prefix_reg <= PREFIX_W'(AW) - size_log;
            last_reg   <= status.last;
        end
    end

    assign block_base    = base_reg;
    assign prefix_length = prefix_reg;
    assign last_block    = last_reg;

endmodule

### hw/rtl/range_to_cidr_blocks_top.sv
// Splits an address range into the fewest aligned CIDR blocks, in ascending order.
//
// range_in carries one range per beat: start_address and range_count (1 to 2^32;
// a count of zero is taken and yields no block; a count past the top address is
// clamped so the range ends at the top). block_out carries one CIDR block per
// beat: block_base, prefix_length, and last_block set on the final block.
// The first block is valid after the range is loaded and its first step writes
// the output register. Throughput: one block per cycle while the receiver takes
// them; a range of N blocks (N <= 2*ADDRESS_WIDTH-2) keeps the block busy until
// its last step. The rate comes from the single block-step datapath, which picks
// the block size, advances the address and reduces the remaining count each cycle.
// range_in.ready is high only between ranges; the next range is taken the
// cycle after the last block enters the output register, even if it waits.
// When block_out is stalled the output register holds its beat and the step
// sequence pauses. Reset clears the controller and drops block_out.valid.
module range_to_cidr_blocks_top #(
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rtcb_in_if.sink     range_in,
    rtcb_out_if.source  block_out
);
    import rtcb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    rtcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (range_in.valid),
        .in_ready  (range_in.ready),
        .out_valid (block_out.valid),
        .out_ready (block_out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    rtcb_dp #(
        .ADDRESS_WIDTH (ADDRESS_WIDTH)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .status        (status),
        .start_address (range_in.start_address),
        .range_count   (range_in.range_count),
        .block_base    (block_out.block_base),
        .prefix_length (block_out.prefix_length),
        .last_block    (block_out.last_block)
    );

`ifndef SYNTHESIS
    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && status.last |=> range_in.ready)
        else $error("input not ready after last block");

    a_load_busies_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !range_in.ready)
        else $error("input ready while a range is in progress");

    a_step_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> !block_out.valid || block_out.ready)
        else $error("block overwritten while output stalled");

    a_prefix_range: assert property (@(posedge clk) disable iff (!rst_n)
        block_out.valid |-> block_out.prefix_length <= PREFIX_W'(ADDRESS_WIDTH))
        else $error("prefix length out of range");
`endif

endmodule
